@@ src/bpfm_pkg.sv @@
// ----------------------------------------------------------------------------
// bpfm_pkg: shared types and constants of the buffer pool frame manager.
// Holds the item structs, status codes and the frame record layout.
// ----------------------------------------------------------------------------
package bpfm_pkg;

  localparam int unsigned Frames = 16;
  localparam int unsigned FrameW = $clog2(Frames);
  localparam int unsigned CntW   = $clog2(Frames + 1);

  localparam logic [1:0] OP_PIN    = 2'd0;
  localparam logic [1:0] OP_NEW    = 2'd1;
  localparam logic [1:0] OP_UNPIN  = 2'd2;
  localparam logic [1:0] OP_SKIP   = 2'd3;

  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_LOADED  = 3'd1;
  localparam logic [2:0] ST_PLACED  = 3'd2;
  localparam logic [2:0] ST_NOFRAME = 3'd3;
  localparam logic [2:0] ST_ABSENT  = 3'd4;
  localparam logic [2:0] ST_REFUSED = 3'd5;
  localparam logic [2:0] ST_FULL    = 3'd6;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  file_id;
    logic [23:0] block_no;
    logic        dirty;
  } bpfm_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  frame;
    logic        write_back;
    logic [7:0]  wb_file_id;
    logic [23:0] wb_block_no;
  } bpfm_out_t;

  // One frame record as stored in the frame memory.
  typedef struct packed {
    logic        valid;
    logic [7:0]  file_id;
    logic [23:0] block_no;
    logic [7:0]  pins;
    logic        dirty;
    logic [31:0] stamp;
  } frame_rec_t;

  localparam int unsigned RecW = $bits(frame_rec_t);

endpackage

@@ src/bpfm_ram.sv @@
// ----------------------------------------------------------------------------
// bpfm_ram: generic single-port-write, single-port-read RAM.
// The read data is registered and appears in the cycle after the address.
// ----------------------------------------------------------------------------
module bpfm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ src/buffer_pool_frame_manager.sv @@
// ----------------------------------------------------------------------------
// buffer_pool_frame_manager: LRU buffer pool frame table.
// Pins and unpins (file, block) keys over a fully associative frame pool.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid_i/stall_o | bpfm_in_t
//  out     | output    | out_valid_o/stall_i| bpfm_out_t
//
// An item is handled as a scan with one read per frame from the frame memory
// (whose read data is registered), then a decision and at most one write back.
// After reset a clearing pass writes every record to zero;
// no item is accepted then. A result waits in the output register while the
// next item is already being scanned; the scan stalls only at its end if the
// previous result has not been taken.
module buffer_pool_frame_manager
  import bpfm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  bpfm_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output bpfm_out_t out_data_o
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DONE  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;     // read address issued
  logic              rv_q, rv_d;       // read data valid
  logic [FrameW-1:0] ridx_q, ridx_d;   // index of read data
  bpfm_in_t          req_q, req_d;
  logic [31:0]       stamp_q, stamp_d;

  logic              hit_q, hit_d;
  logic [FrameW-1:0] hidx_q, hidx_d;
  frame_rec_t        hrec_q, hrec_d;
  logic              free_q, free_d;   // never-used frame found
  logic              vic_q, vic_d;     // any candidate found
  logic [FrameW-1:0] vidx_q, vidx_d;
  frame_rec_t        vrec_q, vrec_d;
  logic [31:0]       vage_q, vage_d;

  logic              out_valid_q, out_valid_d;
  bpfm_out_t         out_q, out_d;

  logic              we;
  logic [FrameW-1:0] waddr;
  frame_rec_t        wrec, rrec;
  logic [31:0]       age;

  bpfm_ram #(.Width(RecW), .Depth(Frames)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wrec),
    .raddr_i (cnt_q[FrameW-1:0]),
    .rdata_o (rrec)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign age         = stamp_q - rrec.stamp;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; rv_d = 1'b0; ridx_d = ridx_q;
    req_d = req_q; stamp_d = stamp_q;
    hit_d = hit_q; hidx_d = hidx_q; hrec_d = hrec_q;
    free_d = free_q; vic_d = vic_q; vidx_d = vidx_q; vrec_d = vrec_q;
    vage_d = vage_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d = out_q;
    we = 1'b0; waddr = '0; wrec = '0;
    unique case (state_q)
      S_CLEAR: begin
        we = 1'b1;
        waddr = cnt_q[FrameW-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(Frames - 1)) begin
          cnt_d = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        cnt_d = '0;
        if (in_valid_i && in_data_i.op != OP_SKIP) begin
          req_d = in_data_i;
          hit_d = 1'b0; free_d = 1'b0; vic_d = 1'b0;
          cnt_d = CntW'(1);
          rv_d = 1'b1; ridx_d = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_q != CntW'(Frames)) begin
          rv_d = 1'b1;
          ridx_d = cnt_q[FrameW-1:0];
          cnt_d = cnt_q + 1'b1;
        end
        if (rv_q) begin
          if (rrec.valid && rrec.file_id == req_q.file_id &&
              rrec.block_no == req_q.block_no && !hit_q) begin
            hit_d = 1'b1; hidx_d = ridx_q; hrec_d = rrec;
          end
          if (!rrec.valid) begin
            if (!free_q) begin
              free_d = 1'b1; vic_d = 1'b1; vidx_d = ridx_q; vrec_d = rrec;
            end
          end else if (!free_q && rrec.pins == 8'd0 && (!vic_q || age > vage_q)) begin
            vic_d = 1'b1; vidx_d = ridx_q; vrec_d = rrec; vage_d = age;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d = '0;
          waddr = hidx_q;
          cnt_d = '0;
          state_d = S_IDLE;
          if (req_q.op == OP_UNPIN) begin
            if (!hit_q) begin
              out_d.status = ST_ABSENT;
            end else if (hrec_q.pins == 8'd0) begin
              out_d.status = ST_REFUSED; out_d.frame = 4'(hidx_q);
            end else begin
              we = 1'b1; wrec = hrec_q;
              wrec.dirty = hrec_q.dirty | req_q.dirty;
              wrec.pins = hrec_q.pins - 8'd1;
              if (hrec_q.pins == 8'd1) begin
                wrec.stamp = stamp_q;
                stamp_d = stamp_q + 32'd1;
              end
              out_d.status = ST_HIT; out_d.frame = 4'(hidx_q);
            end
          end else if (hit_q) begin
            out_d.frame = 4'(hidx_q);
            if (req_q.op == OP_NEW) begin
              out_d.status = ST_REFUSED;
            end else if (hrec_q.pins == 8'hFF) begin
              out_d.status = ST_FULL;
            end else begin
              we = 1'b1; wrec = hrec_q; wrec.pins = hrec_q.pins + 8'd1;
              out_d.status = ST_HIT;
            end
          end else if (!vic_q) begin
            out_d.status = ST_NOFRAME;
          end else begin
            we = 1'b1; waddr = vidx_q;
            wrec = '0;
            wrec.valid = 1'b1; wrec.file_id = req_q.file_id;
            wrec.block_no = req_q.block_no; wrec.pins = 8'd1;
            wrec.stamp = vrec_q.stamp;
            out_d.status = (req_q.op == OP_PIN) ? ST_LOADED : ST_PLACED;
            out_d.frame = 4'(vidx_q);
            if (vrec_q.valid && vrec_q.dirty) begin
              out_d.write_back = 1'b1;
              out_d.wb_file_id = vrec_q.file_id;
              out_d.wb_block_no = vrec_q.block_no;
            end
          end
        end
      end
      S_EMIT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; cnt_q <= '0; rv_q <= 1'b0;
      stamp_q <= '0; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; rv_q <= rv_d;
      stamp_q <= stamp_d; out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= ridx_d; req_q <= req_d;
    hit_q <= hit_d; hidx_q <= hidx_d; hrec_q <= hrec_d;
    free_q <= free_d; vic_q <= vic_d; vidx_q <= vidx_d; vrec_q <= vrec_d;
    vage_q <= vage_d; out_q <= out_d;
  end

  // A pending result must not be overwritten while stalled.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_q))
    else $error("result overwritten while stalled");

  // Writes to the frame memory happen only in clearing or decision.
  a_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == S_CLEAR || state_q == S_DONE))
    else $error("unexpected frame memory write");

  // No item is accepted during a scan.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> in_stall_o)
    else $error("item accepted while busy");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the buffer pool frame manager.
// Drives pin, new-block pin, unpin and skip items over a small key space, predicts
// every result with a behavioral frame table and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;
  import bpfm_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  bpfm_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  bpfm_out_t out_data_o;

  buffer_pool_frame_manager dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  localparam int unsigned CycleLimit = 900000;
  localparam int ExpDepth = 256;

  // Predicted frame table.
  logic        tbl_valid [Frames];
  logic [7:0]  tbl_file  [Frames];
  logic [23:0] tbl_block [Frames];
  logic [7:0]  tbl_pins  [Frames];
  logic        tbl_dirty [Frames];
  logic [31:0] tbl_stamp [Frames];
  logic [31:0] stamp_now;

  // Expected results in order, as a ring with running write and read counts.
  bpfm_out_t exp_fifo [ExpDepth];
  int  exp_wr = 0;
  int  exp_rd = 0;
  int  errors = 0;
  int  results_seen = 0;
  int  items_sent = 0;
  int  writebacks_seen = 0;
  bit  sink_idle_on = 1;
  bit  src_idle_on = 1;
  bit  sink_hold = 0;
  int  cycle_count = 0;

  logic [7:0]  key_file  [8];
  logic [23:0] key_block [8];

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t timeout", $time);
      $display("[buffer_pool_frame_manager] ERROR");
      $finish;
    end
  end

  function automatic bpfm_out_t predict_frame_op(bpfm_in_t it);
    bpfm_out_t r;
    int hit;
    int vic;
    logic [31:0] best_age;
    r = '0;
    hit = -1;
    vic = -1;
    best_age = '0;
    for (int i = 0; i < Frames; i++)
      if (hit < 0 && tbl_valid[i] && tbl_file[i] == it.file_id
          && tbl_block[i] == it.block_no) hit = i;
    if (it.op == OP_UNPIN) begin
      if (hit < 0) r.status = ST_ABSENT;
      else if (tbl_pins[hit] == 0) begin
        r.status = ST_REFUSED;
        r.frame = hit[3:0];
      end else begin
        tbl_dirty[hit] = tbl_dirty[hit] | it.dirty;
        tbl_pins[hit] = tbl_pins[hit] - 8'd1;
        if (tbl_pins[hit] == 0) begin
          tbl_stamp[hit] = stamp_now;
          stamp_now = stamp_now + 32'd1;
        end
        r.status = ST_HIT;
        r.frame = hit[3:0];
      end
      return r;
    end
    if (hit >= 0) begin
      r.frame = hit[3:0];
      if (it.op == OP_NEW) r.status = ST_REFUSED;
      else if (tbl_pins[hit] == 8'hFF) r.status = ST_FULL;
      else begin
        tbl_pins[hit] = tbl_pins[hit] + 8'd1;
        r.status = ST_HIT;
      end
      return r;
    end
    for (int i = 0; i < Frames; i++)
      if (vic < 0 && !tbl_valid[i]) vic = i;
    if (vic < 0)
      for (int i = 0; i < Frames; i++)
        if (tbl_pins[i] == 0 && (vic < 0 || stamp_now - tbl_stamp[i] > best_age)) begin
          vic = i;
          best_age = stamp_now - tbl_stamp[i];
        end
    if (vic < 0) begin
      r.status = ST_NOFRAME;
      return r;
    end
    if (tbl_valid[vic] && tbl_dirty[vic]) begin
      r.write_back = 1'b1;
      r.wb_file_id = tbl_file[vic];
      r.wb_block_no = tbl_block[vic];
    end
    tbl_valid[vic] = 1'b1;
    tbl_file[vic] = it.file_id;
    tbl_block[vic] = it.block_no;
    tbl_pins[vic] = 8'd1;
    tbl_dirty[vic] = 1'b0;
    r.status = (it.op == OP_PIN) ? ST_LOADED : ST_PLACED;
    r.frame = vic[3:0];
    return r;
  endfunction

  // Sends one item; it is held until accepted, then predicted unless it is a skip.
  task automatic send_item(logic [1:0] op, logic [7:0] f, logic [23:0] b, logic d);
    bpfm_in_t it;
    it = '{op: op, file_id: f, block_no: b, dirty: d};
    if (src_idle_on && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
      while (src_idle_on && $urandom_range(99) < 29) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (op != OP_SKIP) begin
      exp_fifo[exp_wr % ExpDepth] = predict_frame_op(it);
      exp_wr++;
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_key(logic [1:0] op, int k, logic d);
    send_item(op, key_file[k], key_block[k], d);
  endtask

  // Result checker and receiver stall generator.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (exp_wr == exp_rd) begin
        $display("%0t unexpected result %p", $time, out_data_o);
        errors++;
      end else begin
        bpfm_out_t e;
        e = exp_fifo[exp_rd % ExpDepth];
        exp_rd++;
        if (out_data_o.status !== e.status || out_data_o.frame !== e.frame
            || out_data_o.write_back !== e.write_back
            || out_data_o.wb_file_id !== e.wb_file_id
            || out_data_o.wb_block_no !== e.wb_block_no) begin
          $display("%0t mismatch: expected %p actual %p", $time, e, out_data_o);
          errors++;
        end
        if (out_data_o.write_back) writebacks_seen++;
      end
      results_seen++;
    end
  end

  always @(negedge clk_i)
    out_stall_i <= sink_hold || (sink_idle_on && $urandom_range(99) < 29);

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (exp_wr != exp_rd) @(negedge clk_i);
    repeat (4 * Frames) @(negedge clk_i);
  endtask

  task automatic test_directed();
    send_key(OP_UNPIN, 0, 1'b0);
    send_item(OP_PIN, 8'h00, 24'h000000, 1'b0);
    send_item(OP_PIN, 8'hFF, 24'hFFFFFF, 1'b1);
    send_item(OP_NEW, 8'hFF, 24'hFFFFFF, 1'b0);
    send_item(OP_NEW, 8'hA5, 24'h5A5A5A, 1'b0);
    send_item(OP_SKIP, 8'h12, 24'h345678, 1'b1);
    send_item(OP_UNPIN, 8'h00, 24'h000000, 1'b1);
    send_item(OP_UNPIN, 8'h00, 24'h000000, 1'b0);
    send_item(OP_UNPIN, 8'hFF, 24'hFFFFFF, 1'b0);
    send_item(OP_UNPIN, 8'hA5, 24'h5A5A5A, 1'b1);
    wait_drained();
  endtask

  // Fill every frame pinned to reach no-frame, then release and evict dirty.
  task automatic test_pool_exhaust();
    for (int i = 0; i < Frames + 2; i++) send_item(OP_PIN, 8'h40, 24'(i + 100), 1'b0);
    send_item(OP_NEW, 8'h41, 24'h1, 1'b0);
    for (int i = 0; i < Frames; i++) send_item(OP_UNPIN, 8'h40, 24'(i + 100), i[0]);
    for (int i = 0; i < Frames; i++) send_item(OP_PIN, 8'h42, 24'(i), 1'b0);
    for (int i = 0; i < Frames; i++) send_item(OP_UNPIN, 8'h42, 24'(i), 1'b1);
    wait_drained();
  endtask

  // Saturate one pin count and walk it back down.
  task automatic test_pin_full();
    for (int i = 0; i < 258; i++) send_item(OP_PIN, 8'h77, 24'h777777, 1'b0);
    for (int i = 0; i < 256; i++) send_item(OP_UNPIN, 8'h77, 24'h777777, 1'b0);
    wait_drained();
  endtask

  // Receiver holds off while the sender keeps offering items.
  task automatic test_backpressure();
    sink_hold = 1;
    fork
      begin
        repeat (400) @(negedge clk_i);
        sink_hold = 0;
      end
      for (int i = 0; i < 30; i++) send_item(OP_PIN, 8'h55, 24'(i % 20), 1'b0);
    join
    for (int i = 0; i < 20; i++) send_item(OP_UNPIN, 8'h55, 24'(i), 1'b1);
    wait_drained();
  endtask

  // Random traffic over a small key set, mostly pins and unpins of keys from the set, plus skip and random-key items.
  task automatic test_random(int n, bit quiet);
    int k;
    int r;
    src_idle_on = !quiet;
    sink_idle_on = !quiet;
    for (int j = 0; j < 8; j++) begin
      key_file[j] = 8'($urandom);
      key_block[j] = 24'($urandom);
    end
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(7);
      if (i % 64 == 0) key_block[k] = 24'($urandom);
      r = $urandom_range(99);
      if (r < 40) send_key(OP_PIN, k, 1'($urandom));
      else if (r < 50) send_key(OP_NEW, k, 1'($urandom));
      else if (r < 95) send_key(OP_UNPIN, k, 1'($urandom));
      else if (r < 97) send_item(OP_SKIP, 8'($urandom), 24'($urandom), 1'($urandom));
      else send_item(2'($urandom_range(2)), 8'($urandom), 24'($urandom), 1'($urandom));
    end
    src_idle_on = 1;
    sink_idle_on = 1;
    wait_drained();
  endtask

  initial begin
    rst_ni = 0;
    in_valid_i = 0;
    in_data_i = '0;
    out_stall_i = 0;
    for (int i = 0; i < Frames; i++) begin
      tbl_valid[i] = 0; tbl_file[i] = 0; tbl_block[i] = 0;
      tbl_pins[i] = 0; tbl_dirty[i] = 0; tbl_stamp[i] = 0;
    end
    stamp_now = 0;
    for (int j = 0; j < 8; j++) begin
      key_file[j] = 8'(j); key_block[j] = 24'(j);
    end
    repeat (7) @(negedge clk_i);
    rst_ni = 1;
    test_directed();
    test_pool_exhaust();
    test_pin_full();
    test_backpressure();
    test_random(400, 0);
    test_random(150, 1);
    test_random(260, 0);
    $display("Sent %0d items, checked %0d results, %0d write-backs seen.",
             items_sent, results_seen, writebacks_seen);
    $display("Covered miss, hit, eviction, no-frame, refusals, pin saturation and stalls.");
    if (errors == 0 && exp_wr == exp_rd)
      $display("[buffer_pool_frame_manager] OK");
    else
      $display("[buffer_pool_frame_manager] ERROR");
    $finish;
  end
endmodule
